// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/mppt_po_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MPPT perturb-and-observe package
// Payload types, register state, mode codes and register indexes.
// ---------------------------------------------------------------------------
package mppt_po_pkg;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_ON   = 2'd1,
        MODE_AUTO = 2'd2,
        MODE_SCAN = 2'd3
    } t_mode;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_BUTTON = 1'b1;

    localparam logic [1:0] BTN_NONE = 2'd0;
    localparam logic [1:0] BTN_MODE = 2'd1;
    localparam logic [1:0] BTN_UP   = 2'd2;
    localparam logic [1:0] BTN_DOWN = 2'd3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_STOP_POWER      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_ON_VOLTAGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_ENABLE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHASE_DIVIDER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RESCAN_PERIOD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_HOLD      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_HOLD     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_STEP     = 3'd7;

    typedef struct packed {
        logic               operation;
        logic [1:0]         button;
        logic signed [15:0] panel_power;
        logic [15:0]        panel_voltage;
        logic               battery_overvoltage;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         duty_cycle;
        logic               converter_on;
        logic [1:0]         mode;
        logic signed [15:0] peak_power;
        logic [7:0]         peak_duty;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] stop_power;
        logic [15:0]        turn_on_voltage;
        logic               scan_enable;
        logic [7:0]         chase_divider;
        logic [15:0]        rescan_period;
        logic [15:0]        sweep_hold;
        logic [15:0]        settle_hold;
        logic [7:0]         button_step;
    } t_cfg;

    typedef struct packed {
        t_mode              mode;
        logic               run_request;
        logic               enabled;
        logic [7:0]         duty;
        logic               dir_down;
        logic signed [15:0] prev_power;
        logic [7:0]         chase_count;
        logic               chase_tick;
        logic [15:0]        scan_count;
        logic               rescan_due;
        logic [15:0]        pre_delay;
        logic [15:0]        post_delay;
        logic signed [15:0] best_power;
        logic [7:0]         best_duty;
    } t_state;

endpackage

// ----- rtl/mppt_perturb_observe_controller.sv -----
`timescale 1ns / 1ps
// Path: an accepted beat waits in the input register, then the state update writes its
// result into the output register or the skid slot in one pass.
// Throughput: one beat per cycle while the results are taken.
// An output register plus one skid slot hold results under output stall; intake
// stalls while the input register is full and the skid slot is occupied.
// Synchronous reset puts state in off mode with duty PWM_TOP/2, registers at defaults.
// ---------------------------------------------------------------------------
// MPPT perturb-and-observe controller
// Solar charger PWM duty control: mode machine, scan sweep and P&O chase.
// ---------------------------------------------------------------------------
module mppt_perturb_observe_controller #(
    parameter int PWM_TOP = 100
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [mppt_po_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mppt_po_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  mppt_po_pkg::t_in_item                  i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output mppt_po_pkg::t_out_item                 o_out_data
);
    import mppt_po_pkg::*;

    localparam logic [7:0] DutyReset = 8'(PWM_TOP / 2);

    t_cfg      r_cfg;
    t_state    r_state;
    t_state    n_state;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      r_skid_valid;
    t_out_item r_skid_item;
    t_out_item n_result;

    logic in_accept;
    logic fire;
    logic out_take;

    assign fire       = r_in_valid && !r_skid_valid;
    assign o_in_stall = r_in_valid && r_skid_valid;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;

    mppt_po_step #(
        .PWM_TOP (PWM_TOP)
    ) u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // configuration and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stop_power      <= '0;
            r_cfg.turn_on_voltage <= '0;
            r_cfg.scan_enable     <= 1'b0;
            r_cfg.chase_divider   <= 8'd1;
            r_cfg.rescan_period   <= 16'd1;
            r_cfg.sweep_hold      <= '0;
            r_cfg.settle_hold     <= '0;
            r_cfg.button_step     <= 8'd1;
            r_state.mode          <= MODE_OFF;
            r_state.run_request   <= 1'b0;
            r_state.enabled       <= 1'b0;
            r_state.duty          <= DutyReset;
            r_state.dir_down      <= 1'b0;
            r_state.prev_power    <= '0;
            r_state.chase_count   <= 8'd1;
            r_state.chase_tick    <= 1'b0;
            r_state.scan_count    <= 16'd1;
            r_state.rescan_due    <= 1'b0;
            r_state.pre_delay     <= '0;
            r_state.post_delay    <= '0;
            r_state.best_power    <= '0;
            r_state.best_duty     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_STOP_POWER:      r_cfg.stop_power      <= i_cfg_data;
                    CFG_TURN_ON_VOLTAGE: r_cfg.turn_on_voltage <= i_cfg_data;
                    CFG_SCAN_ENABLE:     r_cfg.scan_enable     <= i_cfg_data[0];
                    CFG_CHASE_DIVIDER:   r_cfg.chase_divider   <= i_cfg_data[7:0];
                    CFG_RESCAN_PERIOD:   r_cfg.rescan_period   <= i_cfg_data;
                    CFG_SWEEP_HOLD:      r_cfg.sweep_hold      <= i_cfg_data;
                    CFG_SETTLE_HOLD:     r_cfg.settle_hold     <= i_cfg_data;
                    CFG_BUTTON_STEP:     r_cfg.button_step     <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (fire) begin
                r_state <= n_state;
            end
        end
    end

    // handshake control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                // skid is empty whenever a beat fires
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_data;
        end
        if (fire) begin
            if (!r_out_valid || out_take) begin
                r_out_item <= n_result;
            end else begin
                r_skid_item <= n_result;
            end
        end else if (out_take && r_skid_valid) begin
            r_out_item <= r_skid_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

// ----- rtl/mppt_po_step.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MPPT step logic
// Next controller state and result for one control tick or button beat.
// ---------------------------------------------------------------------------
module mppt_po_step #(
    parameter int PWM_TOP = 100
) (
    input  mppt_po_pkg::t_state    i_state,
    input  mppt_po_pkg::t_cfg      i_cfg,
    input  mppt_po_pkg::t_in_item  i_item,
    output mppt_po_pkg::t_state    o_state,
    output mppt_po_pkg::t_out_item o_result
);
    import mppt_po_pkg::*;

    localparam logic [7:0] DutyMax = 8'(PWM_TOP - 1);

    function automatic t_state begin_scan(t_state st, t_cfg c);
        t_state r;
        r            = st;
        r.mode       = MODE_SCAN;
        r.rescan_due = 1'b0;
        r.best_duty  = '0;
        r.best_power = '0;
        r.duty       = '0;
        r.pre_delay  = c.sweep_hold;
        r.scan_count = c.rescan_period;
        return r;
    endfunction

    function automatic t_state begin_auto(t_state st, t_cfg c);
        t_state r;
        r            = st;
        r.mode       = MODE_AUTO;
        r.duty       = st.best_duty;
        r.post_delay = c.settle_hold;
        return r;
    endfunction

    logic signed [15:0] p;
    assign p = i_item.panel_power;

    t_state     s;
    logic [8:0] up_sum;

    always_comb begin
        s      = i_state;
        up_sum = '0;
        if (i_item.operation == OP_TICK) begin
            unique case (s.mode)
                MODE_ON, MODE_SCAN: s.run_request = 1'b1;
                MODE_OFF:           s.run_request = 1'b0;
                MODE_AUTO: begin
                    if (s.post_delay != '0) begin
                        s.post_delay = s.post_delay - 16'd1;
                    end else if (s.enabled && ($signed(p) < $signed(i_cfg.stop_power))) begin
                        s.run_request = 1'b0;
                    end
                    if (!s.enabled && (i_item.panel_voltage > i_cfg.turn_on_voltage)) begin
                        s.run_request = 1'b1;
                    end
                    s.scan_count = s.scan_count - 16'd1;
                    if (s.scan_count == '0) begin
                        s.rescan_due = 1'b1;
                        s.scan_count = i_cfg.rescan_period;
                    end
                    if (s.enabled && s.rescan_due && i_cfg.scan_enable) begin
                        s = begin_scan(s, i_cfg);
                    end
                end
                default: ;
            endcase

            s.chase_count = s.chase_count - 8'd1;
            if (s.chase_count == '0) begin
                s.chase_tick  = 1'b1;
                s.chase_count = i_cfg.chase_divider;
            end

            if (!i_item.battery_overvoltage && s.run_request) begin
                s.enabled = 1'b1;
                if (s.chase_tick) begin
                    s.chase_tick = 1'b0;
                    if (s.mode == MODE_SCAN) begin
                        if (s.pre_delay != '0) begin
                            s.pre_delay = s.pre_delay - 16'd1;
                        end else begin
                            // record the peak, then climb until the top edge
                            if ($signed(p) > $signed(s.best_power)) begin
                                s.best_power = p;
                                s.best_duty  = s.duty;
                            end
                            if (s.duty < DutyMax) begin
                                s.duty = s.duty + 8'd1;
                            end else begin
                                s = begin_auto(s, i_cfg);
                            end
                        end
                    end else begin
                        // reverse on a power drop, bounce off both duty edges
                        if ($signed(p) < $signed(s.prev_power)) begin
                            s.dir_down = !s.dir_down;
                        end
                        s.prev_power = p;
                        if (s.duty == '0) begin
                            s.dir_down = 1'b0;
                        end else if (s.duty >= DutyMax) begin
                            s.dir_down = 1'b1;
                        end
                        s.duty = s.dir_down ? (s.duty - 8'd1) : (s.duty + 8'd1);
                    end
                end
            end else begin
                s.enabled = 1'b0;
            end
        end else begin
            case (i_item.button)
                BTN_MODE: begin
                    unique case (s.mode)
                        MODE_OFF:  s = begin_scan(s, i_cfg);
                        MODE_SCAN: s = begin_auto(s, i_cfg);
                        MODE_AUTO: s.mode = MODE_ON;
                        MODE_ON:   s.mode = MODE_OFF;
                        default:   ;
                    endcase
                end
                BTN_UP: begin
                    if (s.duty < DutyMax) begin
                        up_sum = {1'b0, s.duty} + {1'b0, i_cfg.button_step};
                        s.duty = (up_sum > {1'b0, DutyMax}) ? DutyMax : up_sum[7:0];
                    end
                end
                BTN_DOWN: begin
                    if (s.duty != '0) begin
                        s.duty = (s.duty > i_cfg.button_step) ?
                                 (s.duty - i_cfg.button_step) : 8'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_state               = s;
    assign o_result.duty_cycle   = s.duty;
    assign o_result.converter_on = s.enabled;
    assign o_result.mode         = 2'(s.mode);
    assign o_result.peak_power   = s.best_power;
    assign o_result.peak_duty    = s.best_duty;

endmodule

// ----- rtl/mppt_po_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MPPT controller checker
// Port-level checks on the result buffer and the duty ranges.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mppt_po_checker #(
    parameter int PWM_TOP = 100
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   o_in_stall,
    input  logic                   o_out_valid,
    input  logic                   i_out_stall,
    input  mppt_po_pkg::t_out_item o_out_data
);
    localparam logic [7:0] DutyMax = 8'(PWM_TOP - 1);

    // a stalled result beat holds
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // intake only stalls when both result slots are full
    `CHK_SAME(a_stall_needs_result, i_clk, i_rst_n, o_in_stall, o_out_valid)

    `CHK_SAME(a_duty_range, i_clk, i_rst_n, o_out_valid, o_out_data.duty_cycle <= DutyMax)

    `CHK_SAME(a_peak_duty_range, i_clk, i_rst_n, o_out_valid, o_out_data.peak_duty <= DutyMax)

endmodule

bind mppt_perturb_observe_controller mppt_po_checker #(
    .PWM_TOP (PWM_TOP)
) u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MPPT perturb-and-observe controller testbench
// Drives control ticks and button events through the valid/stall input,
// predicts each result beat with an in-bench copy of the duty controller
// and compares the beats field by field, under random sender bursts,
// receiver stalls and register settings that change between phases.
// ---------------------------------------------------------------------------
module tb_top;
    import mppt_po_pkg::*;

    localparam int         PWM_TOP          = 100;
    localparam logic [7:0] DUTY_TOP         = 8'(PWM_TOP - 1);
    localparam int         LONG_HOLD_CYCLES = 100;
    localparam int         RANDOM_PHASES    = 10;
    localparam int         PHASE_ITEMS      = 190;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_style;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;

    // predicted controller state and its register copy
    t_state    ctrl_st;
    t_cfg      ctrl_cfg;
    t_out_item expected_results[$];

    int           fail_count = 0;
    int           burst_left = 0;
    logic         hold_req   = 1'b0;
    int           hold_left  = 0;
    t_stall_style stall_style = STALL_NONE;
    int           style_left = 0;

    // power curve over duty that the random ticks follow
    int curve_peak  = 50;
    int curve_top   = 10000;
    int curve_slope = 100;

    mppt_perturb_observe_controller #(
        .PWM_TOP(PWM_TOP)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Duty controller prediction
    // ------------------------------------------------------------------
    function automatic void enter_scan();
        ctrl_st.mode       = MODE_SCAN;
        ctrl_st.rescan_due = 1'b0;
        ctrl_st.best_duty  = '0;
        ctrl_st.best_power = '0;
        ctrl_st.duty       = '0;
        ctrl_st.pre_delay  = ctrl_cfg.sweep_hold;
        ctrl_st.scan_count = ctrl_cfg.rescan_period;
    endfunction

    function automatic void enter_auto();
        ctrl_st.mode       = MODE_AUTO;
        ctrl_st.duty       = ctrl_st.best_duty;
        ctrl_st.post_delay = ctrl_cfg.settle_hold;
    endfunction

    function automatic t_out_item apply_control_item(t_in_item it);
        logic signed [15:0] pw;
        logic [8:0]         raised;
        t_out_item          r;
        pw = it.panel_power;
        if (it.operation == OP_TICK) begin
            if (ctrl_st.mode == MODE_ON || ctrl_st.mode == MODE_SCAN) begin
                ctrl_st.run_request = 1'b1;
            end else if (ctrl_st.mode == MODE_OFF) begin
                ctrl_st.run_request = 1'b0;
            end else begin
                if (ctrl_st.post_delay != 0) begin
                    ctrl_st.post_delay = ctrl_st.post_delay - 16'd1;
                end else if (ctrl_st.enabled &&
                             $signed(pw) < $signed(ctrl_cfg.stop_power)) begin
                    ctrl_st.run_request = 1'b0;
                end
                if (!ctrl_st.enabled && it.panel_voltage > ctrl_cfg.turn_on_voltage)
                    ctrl_st.run_request = 1'b1;
                ctrl_st.scan_count = ctrl_st.scan_count - 16'd1;
                if (ctrl_st.scan_count == 0) begin
                    ctrl_st.rescan_due = 1'b1;
                    ctrl_st.scan_count = ctrl_cfg.rescan_period;
                end
                if (ctrl_st.enabled && ctrl_st.rescan_due && ctrl_cfg.scan_enable)
                    enter_scan();
            end

            ctrl_st.chase_count = ctrl_st.chase_count - 8'd1;
            if (ctrl_st.chase_count == 0) begin
                ctrl_st.chase_tick  = 1'b1;
                ctrl_st.chase_count = ctrl_cfg.chase_divider;
            end

            if (!it.battery_overvoltage && ctrl_st.run_request) begin
                ctrl_st.enabled = 1'b1;
                if (ctrl_st.chase_tick) begin
                    ctrl_st.chase_tick = 1'b0;
                    if (ctrl_st.mode == MODE_SCAN) begin
                        if (ctrl_st.pre_delay != 0) begin
                            ctrl_st.pre_delay = ctrl_st.pre_delay - 16'd1;
                        end else begin
                            if ($signed(pw) > $signed(ctrl_st.best_power)) begin
                                ctrl_st.best_power = pw;
                                ctrl_st.best_duty  = ctrl_st.duty;
                            end
                            if (ctrl_st.duty < DUTY_TOP)
                                ctrl_st.duty = ctrl_st.duty + 8'd1;
                            else
                                enter_auto();
                        end
                    end else begin
                        // reverse when power dropped, then bounce off the edges
                        if ($signed(pw) < $signed(ctrl_st.prev_power))
                            ctrl_st.dir_down = !ctrl_st.dir_down;
                        ctrl_st.prev_power = pw;
                        if (ctrl_st.duty == 0)
                            ctrl_st.dir_down = 1'b0;
                        else if (ctrl_st.duty >= DUTY_TOP)
                            ctrl_st.dir_down = 1'b1;
                        ctrl_st.duty = ctrl_st.dir_down ? ctrl_st.duty - 8'd1
                                                        : ctrl_st.duty + 8'd1;
                    end
                end
            end else begin
                ctrl_st.enabled = 1'b0;
            end
        end else begin
            case (it.button)
                BTN_MODE: begin
                    case (ctrl_st.mode)
                        MODE_OFF:  enter_scan();
                        MODE_SCAN: enter_auto();
                        MODE_AUTO: ctrl_st.mode = MODE_ON;
                        default:   ctrl_st.mode = MODE_OFF;
                    endcase
                end
                BTN_UP: begin
                    if (ctrl_st.duty < DUTY_TOP) begin
                        raised = {1'b0, ctrl_st.duty} + {1'b0, ctrl_cfg.button_step};
                        ctrl_st.duty = (raised > {1'b0, DUTY_TOP}) ? DUTY_TOP : raised[7:0];
                    end
                end
                BTN_DOWN: begin
                    if (ctrl_st.duty != 0)
                        ctrl_st.duty = (ctrl_st.duty > ctrl_cfg.button_step)
                                     ? ctrl_st.duty - ctrl_cfg.button_step : 8'd0;
                end
                default: ;
            endcase
        end

        r.duty_cycle   = ctrl_st.duty;
        r.converter_on = ctrl_st.enabled;
        r.mode         = ctrl_st.mode;
        r.peak_power   = ctrl_st.best_power;
        r.peak_duty    = ctrl_st.best_duty;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------
    function automatic logic signed [15:0] clamp_power(int v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic t_in_item button_item(logic [1:0] btn);
        t_in_item it;
        it.operation           = OP_BUTTON;
        it.button              = btn;
        it.panel_power         = 16'($urandom_range(0, 65535));
        it.panel_voltage       = 16'($urandom_range(0, 65535));
        it.battery_overvoltage = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_in_item tick_item(logic signed [15:0] pw, logic [15:0] volts,
                                           logic ov);
        t_in_item it;
        it.operation           = OP_TICK;
        it.button              = 2'($urandom_range(0, 3));
        it.panel_power         = pw;
        it.panel_voltage       = volts;
        it.battery_overvoltage = ov;
        return it;
    endfunction

    function automatic t_in_item field_item();
        t_in_item it;
        int       roll;
        int       press_limit;
        int       offset;
        int       noise;
        int       pw;
        int       volts;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            // noise: any value in every field
            it = button_item(2'($urandom_range(0, 3)));
            it.operation = 1'($urandom_range(0, 1));
            return it;
        end
        // leave off mode quickly, rarely break a running sweep
        press_limit = (ctrl_st.mode == MODE_OFF)  ? 150 :
                      (ctrl_st.mode == MODE_SCAN) ? 5 : 20;
        roll = $urandom_range(0, 999);
        if (roll < press_limit)
            return button_item(BTN_MODE);
        if (roll < press_limit + 30)
            return button_item(BTN_UP);
        if (roll < press_limit + 60)
            return button_item(BTN_DOWN);
        if (roll < press_limit + 70)
            return button_item(BTN_NONE);

        offset = int'(ctrl_st.duty) - curve_peak;
        if (offset < 0)
            offset = -offset;
        noise = $urandom_range(0, 100);
        pw = curve_top - curve_slope * offset + noise - 50;
        if ($urandom_range(0, 99) < 4) begin
            noise = $urandom_range(1, 500);
            pw = int'($signed(ctrl_cfg.stop_power)) - noise;
        end
        if (ctrl_cfg.turn_on_voltage != 16'hffff && $urandom_range(0, 99) < 85)
            volts = $urandom_range(int'(ctrl_cfg.turn_on_voltage) + 1, 65535);
        else
            volts = $urandom_range(0, 65535);
        return tick_item(clamp_power(pw), volts[15:0], $urandom_range(0, 99) < 3);
    endfunction

    function automatic t_cfg default_regs();
        t_cfg c;
        c = '0;
        c.chase_divider = 8'd1;
        c.rescan_period = 16'd1;
        c.button_step   = 8'd1;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    task automatic send_item(input t_in_item item);
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall !== 1'b0);
        expected_results.push_back(apply_control_item(item));
    endtask

    task automatic send_paced(input t_in_item item);
        int gap;
        send_item(item);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic program_regs(input t_cfg c);
        write_reg(CFG_STOP_POWER, c.stop_power);
        write_reg(CFG_TURN_ON_VOLTAGE, c.turn_on_voltage);
        write_reg(CFG_SCAN_ENABLE, {15'd0, c.scan_enable});
        write_reg(CFG_CHASE_DIVIDER, {8'd0, c.chase_divider});
        write_reg(CFG_RESCAN_PERIOD, c.rescan_period);
        write_reg(CFG_SWEEP_HOLD, c.sweep_hold);
        write_reg(CFG_SETTLE_HOLD, c.settle_hold);
        write_reg(CFG_BUTTON_STEP, {8'd0, c.button_step});
        cfg_we   <= 1'b0;
        ctrl_cfg = c;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: own stall pattern plus a long hold on request
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            out_stall <= 1'b1;
            hold_left <= LONG_HOLD_CYCLES;
        end else begin
            if (style_left == 0) begin
                stall_style <= t_stall_style'($urandom_range(0, 3));
                style_left  <= $urandom_range(16, 160);
            end else begin
                style_left <= style_left - 1;
            end
            case (stall_style)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
                default:     out_stall <= style_left[3];
            endcase
        end
    end

    task automatic report_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
        fail_count++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
            if (expected_results.size() == 0) begin
                report_field("unexpected result beat", 16'h0, 16'(out_data.duty_cycle));
            end else begin
                want = expected_results.pop_front();
                if (out_data.duty_cycle !== want.duty_cycle)
                    report_field("duty_cycle", 16'(want.duty_cycle),
                                 16'(out_data.duty_cycle));
                if (out_data.converter_on !== want.converter_on)
                    report_field("converter_on", 16'(want.converter_on),
                                 16'(out_data.converter_on));
                if (out_data.mode !== want.mode)
                    report_field("mode", 16'(want.mode), 16'(out_data.mode));
                if (out_data.peak_power !== want.peak_power)
                    report_field("peak_power", want.peak_power, out_data.peak_power);
                if (out_data.peak_duty !== want.peak_duty)
                    report_field("peak_duty", 16'(want.peak_duty), 16'(out_data.peak_duty));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_button_corners();
        t_cfg     c;
        t_in_item quiet;
        c = default_regs();
        c.button_step = 8'd255;
        program_regs(c);
        // no button, all payload bits set
        quiet           = tick_item(16'hffff, 16'hffff, 1'b1);
        quiet.operation = OP_BUTTON;
        quiet.button    = BTN_NONE;
        send_paced(quiet);
        send_paced(button_item(BTN_UP));
        send_paced(button_item(BTN_UP));
        send_paced(button_item(BTN_DOWN));
        send_paced(button_item(BTN_DOWN));
        wait_results_drained();

        c.button_step = 8'd0;
        program_regs(c);
        send_paced(button_item(BTN_UP));
        send_paced(button_item(BTN_DOWN));
        wait_results_drained();

        c.button_step = 8'd1;
        program_regs(c);
        send_paced(button_item(BTN_UP));
        send_paced(button_item(BTN_DOWN));
        // walk the whole mode ring
        repeat (4) send_paced(button_item(BTN_MODE));
        wait_results_drained();
    endtask

    task automatic test_tick_corners();
        t_cfg c;
        c = default_regs();
        c.stop_power  = 16'h8000;
        c.scan_enable = 1'b1;
        program_regs(c);
        // tick while off leaves the chase tick pending
        send_paced(tick_item(16'h7fff, 16'hffff, 1'b0));
        send_paced(button_item(BTN_MODE));
        send_paced(tick_item(16'h8000, 16'h0000, 1'b1));
        send_paced(tick_item(16'h7fff, 16'h0000, 1'b0));
        send_paced(tick_item(16'h8000, 16'hffff, 1'b0));
        send_paced(button_item(BTN_MODE));
        send_paced(tick_item(16'h8000, 16'hffff, 1'b0));
        send_paced(tick_item(16'h0000, 16'h0001, 1'b0));
        send_paced(tick_item(16'h7fff, 16'h8000, 1'b1));
        send_paced(tick_item(16'h0001, 16'h7fff, 1'b0));
        wait_results_drained();
    endtask

    task automatic test_random_phases();
        t_cfg c;
        int   extra;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            c.stop_power      = 16'($urandom_range(0, 3000) - 2000);
            c.turn_on_voltage = 16'($urandom_range(0, 40000));
            c.scan_enable     = 1'($urandom_range(0, 1));
            c.chase_divider   = 8'($urandom_range(1, 3));
            c.rescan_period   = 16'($urandom_range(30, 400));
            c.sweep_hold      = 16'($urandom_range(0, 4));
            c.settle_hold     = 16'($urandom_range(0, 30));
            c.button_step     = 8'($urandom_range(1, 40));
            if (phase == 0) begin
                c = default_regs();
                c.stop_power  = 16'h8000;
                c.scan_enable = 1'b1;
            end else if (phase == 1) begin
                c.stop_power      = 16'h7fff;
                c.turn_on_voltage = 16'hffff;
                c.scan_enable     = 1'b1;
                c.chase_divider   = 8'd255;
                c.rescan_period   = 16'hffff;
                c.sweep_hold      = 16'hffff;
                c.settle_hold     = 16'hffff;
                c.button_step     = 8'd255;
            end else if (phase == 2) begin
                // zero dividers wrap to a full counter period
                c.chase_divider = 8'd0;
                c.rescan_period = 16'd0;
            end
            program_regs(c);
            curve_peak  = $urandom_range(5, 95);
            curve_top   = $urandom_range(500, 30000);
            extra       = $urandom_range(20, 300);
            curve_slope = extra;
            repeat (PHASE_ITEMS) send_paced(field_item());
            wait_results_drained();
        end
    endtask

    task automatic test_backpressure();
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        // keep offering beats against the held output until intake stalls
        repeat (40) send_item(field_item());
        // pause until every result is back, then resume
        wait_results_drained();
        repeat (20) send_paced(field_item());
        wait_results_drained();
    endtask

    initial begin
        ctrl_cfg = default_regs();
        ctrl_st  = '0;
        ctrl_st.mode        = MODE_OFF;
        ctrl_st.duty        = 8'(PWM_TOP / 2);
        ctrl_st.chase_count = ctrl_cfg.chase_divider;
        ctrl_st.scan_count  = ctrl_cfg.rescan_period;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_button_corners();
        test_tick_corners();
        test_random_phases();
        test_backpressure();

        wait_results_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("** mppt_perturb_observe_controller: PASSED **");
        end else begin
            $display("** mppt_perturb_observe_controller: FAILED **");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("** mppt_perturb_observe_controller: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mppt_po_pkg.sv
rtl/mppt_po_step.sv
rtl/mppt_perturb_observe_controller.sv
rtl/mppt_po_checker.sv
test/tb_top.sv
